// ===== rtl/btl_pkg.sv =====
`default_nettype none

package btl_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int FIELD_BITS      = 16;
	localparam int KIND_BITS       = 4;
	localparam int CHAR_BITS       = 8;

	// candidate results per character: cut token, operator, final flush, end marker
	localparam int RES_SLOTS  = 4;
	localparam int RBUF_DEPTH = 4;

	localparam logic [FIELD_BITS-1:0] LINE_MAX = '1;

	localparam logic [KIND_BITS-1:0] KIND_IDENT  = 4'd0;
	localparam logic [KIND_BITS-1:0] KIND_NUMBER = 4'd1;
	localparam logic [KIND_BITS-1:0] KIND_STRING = 4'd2;
	localparam logic [KIND_BITS-1:0] KIND_LPAREN = 4'd3;
	localparam logic [KIND_BITS-1:0] KIND_RPAREN = 4'd4;
	localparam logic [KIND_BITS-1:0] KIND_PLUS   = 4'd5;
	localparam logic [KIND_BITS-1:0] KIND_MINUS  = 4'd6;
	localparam logic [KIND_BITS-1:0] KIND_STAR   = 4'd7;
	localparam logic [KIND_BITS-1:0] KIND_SLASH  = 4'd8;
	localparam logic [KIND_BITS-1:0] KIND_COMMA  = 4'd9;
	localparam logic [KIND_BITS-1:0] KIND_SEMI   = 4'd10;
	localparam logic [KIND_BITS-1:0] KIND_END    = 4'd11;
	localparam logic [KIND_BITS-1:0] KIND_UNTERM = 4'd12;

	localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0a;
	localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;

	typedef struct packed {
		logic [KIND_BITS-1:0]  token_kind;
		logic [FIELD_BITS-1:0] start_offset;
		logic [FIELD_BITS-1:0] token_length;
		logic [FIELD_BITS-1:0] line_number;
		logic [FIELD_BITS-1:0] column_number;
		logic                  last_of_run;
	} tok_t;

	function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
		return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
	endfunction

	function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_op(input logic [CHAR_BITS-1:0] c);
		return c inside {8'h28, 8'h29, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h2c, 8'h3b};
	endfunction

	function automatic logic [KIND_BITS-1:0] op_kind(input logic [CHAR_BITS-1:0] c);
		logic [KIND_BITS-1:0] k;
		case (c)
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h2b:   k = KIND_PLUS;
			8'h2d:   k = KIND_MINUS;
			8'h2a:   k = KIND_STAR;
			8'h2f:   k = KIND_SLASH;
			8'h2c:   k = KIND_COMMA;
			8'h3b:   k = KIND_SEMI;
			default: k = KIND_END;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/btl_char_if.sv =====
`default_nettype none

interface btl_char_if;
	logic                           valid;
	logic                           ready;
	logic [btl_pkg::CHAR_BITS-1:0]  char_code;
	logic                           is_final;

	modport source(output valid, output char_code, output is_final, input ready);
	modport sink(input valid, input char_code, input is_final, output ready);
endinterface

`default_nettype wire

// ===== rtl/btl_tok_if.sv =====
`default_nettype none

interface btl_tok_if;
	logic                            valid;
	logic                            ready;
	logic [btl_pkg::KIND_BITS-1:0]   token_kind;
	logic [btl_pkg::FIELD_BITS-1:0]  start_offset;
	logic [btl_pkg::FIELD_BITS-1:0]  token_length;
	logic [btl_pkg::FIELD_BITS-1:0]  line_number;
	logic [btl_pkg::FIELD_BITS-1:0]  column_number;
	logic                            last_of_run;

	modport source(
		output valid, output token_kind, output start_offset, output token_length,
		output line_number, output column_number, output last_of_run, input ready
	);
	modport sink(
		input valid, input token_kind, input start_offset, input token_length,
		input line_number, input column_number, input last_of_run, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/btl_scan.sv =====
`default_nettype none

module btl_scan #(
	parameter int OFFSET_BITS = btl_pkg::OFFSET_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic [btl_pkg::CHAR_BITS-1:0]                   char_code,
	input  logic                                            is_final,
	input  logic                                            fire,
	output btl_pkg::tok_t [btl_pkg::RES_SLOTS-1:0]          tok,
	output logic [btl_pkg::RES_SLOTS-1:0]                   tok_valid
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING
	} mode_t;

	localparam int WIDE = (OFFSET_BITS > btl_pkg::FIELD_BITS) ? OFFSET_BITS
		: btl_pkg::FIELD_BITS;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] LEN_ONE = OFFSET_BITS'(1);

	mode_t                             mode_q;
	logic [OFFSET_BITS-1:0]            pos_q;
	logic [OFFSET_BITS-1:0]            pstart_q;
	logic [btl_pkg::FIELD_BITS-1:0]    line_q;
	logic [OFFSET_BITS-1:0]            lstart_q;

	mode_t                             mode_a;
	mode_t                             mode_b;
	logic [OFFSET_BITS-1:0]            next;
	logic [OFFSET_BITS-1:0]            ps_b;
	logic [OFFSET_BITS-1:0]            ls_b;
	logic [btl_pkg::FIELD_BITS-1:0]    line_b;
	logic                              run_idle;
	logic                              c_let;
	logic                              c_dig;

	function automatic logic [btl_pkg::FIELD_BITS-1:0] to_field(
		input logic [OFFSET_BITS-1:0] v
	);
		logic [WIDE-1:0] w;
		w = WIDE'(v);
		return w[btl_pkg::FIELD_BITS-1:0];
	endfunction

	function automatic logic [OFFSET_BITS-1:0] diff_sat0(
		input logic [OFFSET_BITS-1:0] a,
		input logic [OFFSET_BITS-1:0] b
	);
		return (a >= b) ? a - b : '0;
	endfunction

	function automatic btl_pkg::tok_t make_tok(
		input logic [btl_pkg::KIND_BITS-1:0]  kind,
		input logic [OFFSET_BITS-1:0]         start,
		input logic [OFFSET_BITS-1:0]         len,
		input logic [btl_pkg::FIELD_BITS-1:0] line,
		input logic [OFFSET_BITS-1:0]         ls
	);
		btl_pkg::tok_t t;
		t.token_kind    = kind;
		t.start_offset  = to_field(start);
		t.token_length  = to_field(len);
		t.line_number   = line;
		t.column_number = to_field(diff_sat0(start, ls));
		t.last_of_run   = 1'b0;
		return t;
	endfunction

	always_comb begin
		next      = (pos_q == OFF_MAX) ? pos_q : pos_q + LEN_ONE;
		c_let     = btl_pkg::is_letter(char_code);
		c_dig     = btl_pkg::is_digit(char_code);
		tok       = '0;
		tok_valid = '0;
		mode_a    = mode_q;
		run_idle  = 1'b0;

		// token already pending
		case (mode_q)
			MODE_STRING: begin
				if (char_code == btl_pkg::CH_QUOTE) begin
					tok_valid[0] = 1'b1;
					tok[0] = make_tok(btl_pkg::KIND_STRING, pstart_q,
						diff_sat0(pos_q, pstart_q), line_q, lstart_q);
					mode_a = MODE_IDLE;
				end
			end
			MODE_IDENT: begin
				if (!(c_let || c_dig)) begin
					tok_valid[0] = 1'b1;
					mode_a = MODE_IDLE;
					if (char_code == btl_pkg::CH_DOLLAR) begin
						tok[0] = make_tok(btl_pkg::KIND_IDENT, pstart_q, next - pstart_q,
							line_q, lstart_q);
					end else begin
						tok[0] = make_tok(btl_pkg::KIND_IDENT, pstart_q, pos_q - pstart_q,
							line_q, lstart_q);
						run_idle = 1'b1;
					end
				end
			end
			MODE_NUMBER: begin
				if (!c_dig) begin
					tok_valid[0] = 1'b1;
					tok[0] = make_tok(btl_pkg::KIND_NUMBER, pstart_q, pos_q - pstart_q,
						line_q, lstart_q);
					mode_a = MODE_IDLE;
					run_idle = 1'b1;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		// character seen with nothing pending
		mode_b = mode_a;
		ps_b   = pstart_q;
		line_b = line_q;
		ls_b   = lstart_q;
		if (run_idle) begin
			if (char_code == btl_pkg::CH_LF) begin
				line_b = (line_q == btl_pkg::LINE_MAX) ? line_q
					: line_q + btl_pkg::FIELD_BITS'(1);
				ls_b   = next;
			end else if (char_code == btl_pkg::CH_QUOTE) begin
				mode_b = MODE_STRING;
				ps_b   = next;
			end else if (btl_pkg::is_op(char_code)) begin
				tok_valid[1] = 1'b1;
				tok[1] = make_tok(btl_pkg::op_kind(char_code), pos_q, LEN_ONE,
					line_q, lstart_q);
			end else if (c_let) begin
				mode_b = MODE_IDENT;
				ps_b   = pos_q;
			end else if (c_dig) begin
				mode_b = MODE_NUMBER;
				ps_b   = pos_q;
			end
		end

		// end of text
		if (is_final) begin
			case (mode_b)
				MODE_IDENT: begin
					tok_valid[2] = 1'b1;
					tok[2] = make_tok(btl_pkg::KIND_IDENT, ps_b, next - ps_b, line_b, ls_b);
				end
				MODE_NUMBER: begin
					tok_valid[2] = 1'b1;
					tok[2] = make_tok(btl_pkg::KIND_NUMBER, ps_b, next - ps_b, line_b, ls_b);
				end
				MODE_STRING: begin
					tok_valid[2] = 1'b1;
					tok[2] = make_tok(btl_pkg::KIND_UNTERM, ps_b, diff_sat0(next, ps_b),
						line_b, ls_b);
				end
				default: begin
				end
			endcase
			tok_valid[3] = 1'b1;
			tok[3] = make_tok(btl_pkg::KIND_END, next, '0, line_b, ls_b);
		end

		tok[3].last_of_run = is_final;
		tok[1].last_of_run = tok_valid[1] && !is_final;
		tok[0].last_of_run = tok_valid[0] && !tok_valid[1] && !is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			line_q   <= btl_pkg::FIELD_BITS'(1);
			lstart_q <= '0;
		end else if (fire) begin
			if (is_final) begin
				mode_q   <= MODE_IDLE;
				pos_q    <= '0;
				pstart_q <= '0;
				line_q   <= btl_pkg::FIELD_BITS'(1);
				lstart_q <= '0;
			end else begin
				mode_q   <= mode_b;
				pos_q    <= next;
				pstart_q <= ps_b;
				line_q   <= line_b;
				lstart_q <= ls_b;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/btl_rbuf.sv =====
`default_nettype none

module btl_rbuf (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  btl_pkg::tok_t [btl_pkg::RES_SLOTS-1:0]   wr_tok,
	input  logic [btl_pkg::RES_SLOTS-1:0]            wr_en,
	output logic [$clog2(btl_pkg::RBUF_DEPTH+1)-1:0] count,
	btl_tok_if.source                                tokens
);

	localparam int DEPTH = btl_pkg::RBUF_DEPTH;
	localparam int SLOTS = btl_pkg::RES_SLOTS;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	btl_pkg::tok_t     mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  wr_idx [SLOTS];
	logic [PTR_W-1:0]  acc;
	logic [CNT_W-1:0]  n_wr;
	logic              pop;
	btl_pkg::tok_t     head;

	// pack the valid slots into consecutive entries
	always_comb begin
		acc = '0;
		for (int i = 0; i < SLOTS; i++) begin
			wr_idx[i] = wr_ptr_q + acc;
			acc       = acc + PTR_W'(wr_en[i]);
		end
		n_wr = CNT_W'($countones(wr_en));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (wr_en[i]) begin
				mem[wr_idx[i]] <= wr_tok[i];
			end
		end
	end

	assign pop  = tokens.valid && tokens.ready;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_wr);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + n_wr - CNT_W'(pop);
		end
	end

	assign count                = count_q;
	assign tokens.valid         = (count_q != '0);
	assign tokens.token_kind    = head.token_kind;
	assign tokens.start_offset  = head.start_offset;
	assign tokens.token_length  = head.token_length;
	assign tokens.line_number   = head.line_number;
	assign tokens.column_number = head.column_number;
	assign tokens.last_of_run   = head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/basic_token_lexer.sv =====
`default_nettype none

// Character lexer: one source byte enters per cycle on the chars channel and
// the tokens it completes leave on the tokens channel, one per cycle while
// the receiver is ready, in order, with last_of_run on the final token of
// each byte. A byte is held in an input register while the scanner decides
// on it, and its zero to three tokens go into a four-entry result buffer;
// a token passes through both on its way out. The input keeps a rate of one
// byte per cycle as long as the buffer has room for every token of the byte
// in the input register; a byte that yields several tokens (a cut token
// with an operator, or end of text) drains them one at a time, and input
// pauses while the buffer is too full. Offsets are OFFSET_BITS wide and
// saturate; the output fields show their low 16 bits.
module basic_token_lexer #(
	parameter int OFFSET_BITS = btl_pkg::OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	btl_char_if.sink   chars,
	btl_tok_if.source  tokens
);

	localparam int CNT_W  = $clog2(btl_pkg::RBUF_DEPTH + 1);
	localparam int ROOM_W = CNT_W + 1;

	logic                                    valid_s1;
	logic [btl_pkg::CHAR_BITS-1:0]           char_s1;
	logic                                    final_s1;
	logic                                    proc;
	logic                                    room_ok;
	logic [CNT_W-1:0]                        count;
	btl_pkg::tok_t [btl_pkg::RES_SLOTS-1:0]  tok;
	logic [btl_pkg::RES_SLOTS-1:0]           tok_valid;
	logic [btl_pkg::RES_SLOTS-1:0]           wr_en;

	btl_scan #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_s1),
		.is_final  (final_s1),
		.fire      (proc),
		.tok       (tok),
		.tok_valid (tok_valid)
	);

	assign room_ok = (ROOM_W'(count) + ROOM_W'($countones(tok_valid)))
		<= ROOM_W'(btl_pkg::RBUF_DEPTH);
	assign proc        = valid_s1 && room_ok;
	assign chars.ready = !valid_s1 || proc;
	assign wr_en       = tok_valid & {btl_pkg::RES_SLOTS{proc}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1  <= chars.char_code;
			final_s1 <= chars.is_final;
		end
	end

	btl_rbuf u_rbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_tok (tok),
		.wr_en  (wr_en),
		.count  (count),
		.tokens (tokens)
	);

endmodule

`default_nettype wire

// ===== rtl/btl_check.sv =====
`default_nettype none

module btl_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            tok_valid,
	input logic                            tok_ready,
	input logic [btl_pkg::KIND_BITS-1:0]   token_kind,
	input logic [btl_pkg::FIELD_BITS-1:0]  start_offset,
	input logic [btl_pkg::FIELD_BITS-1:0]  token_length,
	input logic [btl_pkg::FIELD_BITS-1:0]  line_number,
	input logic                            last_of_run
);

	// request held until taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("token request dropped before taken");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> $stable(token_kind) && $stable(start_offset)
			&& $stable(token_length) && $stable(last_of_run))
		else $error("token payload changed while stalled");

	// end marker closes the run and has no body
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == btl_pkg::KIND_END |-> last_of_run && token_length == '0)
		else $error("end marker malformed");

	// operators are one character
	a_op_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind >= btl_pkg::KIND_LPAREN && token_kind <= btl_pkg::KIND_SEMI
			|-> token_length == btl_pkg::FIELD_BITS'(1))
		else $error("operator token length not one");

	// lines count from one, kinds stay in range
	a_kind_line: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> token_kind <= btl_pkg::KIND_UNTERM && line_number != '0)
		else $error("token kind or line out of range");

endmodule

bind basic_token_lexer btl_check u_btl_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.tok_valid    (tokens.valid),
	.tok_ready    (tokens.ready),
	.token_kind   (tokens.token_kind),
	.start_offset (tokens.start_offset),
	.token_length (tokens.token_length),
	.line_number  (tokens.line_number),
	.last_of_run  (tokens.last_of_run)
);

`default_nettype wire

// ===== tb/basic_token_lexer_tb.sv =====
module basic_token_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING} scan_t;
	typedef logic [btl_pkg::FIELD_BITS-1:0] field_t;
	typedef logic [btl_pkg::CHAR_BITS-1:0] char_t;
	typedef logic [btl_pkg::KIND_BITS-1:0] kind_t;

	localparam char_t CH_TAB    = 8'h09;
	localparam char_t CH_CR     = 8'h0d;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_STAR   = 8'h2a;
	localparam char_t CH_PLUS   = 8'h2b;
	localparam char_t CH_COMMA  = 8'h2c;
	localparam char_t CH_MINUS  = 8'h2d;
	localparam char_t CH_SLASH  = 8'h2f;
	localparam char_t CH_SEMI   = 8'h3b;

	class token_board;
		btl_pkg::tok_t due_tokens[$];
		btl_pkg::tok_t run_q[$];
		int errors;
		scan_t scan;
		field_t cursor;
		field_t tok_start;
		field_t line_no;
		field_t line_base;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			scan = SCAN_IDLE;
			cursor = '0;
			tok_start = '0;
			line_no = field_t'(1);
			line_base = '0;
		endfunction

		function field_t bump(field_t v);
			return (v == '1) ? v : field_t'(v + 1'b1);
		endfunction

		function bit alpha(char_t c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit numeral(char_t c);
			return c >= "0" && c <= "9";
		endfunction

		function void emit(kind_t kind, field_t start, field_t len);
			btl_pkg::tok_t t;
			t.token_kind = kind;
			t.start_offset = start;
			t.token_length = len;
			t.line_number = line_no;
			t.column_number = (start >= line_base) ? field_t'(start - line_base) : '0;
			t.last_of_run = 1'b0;
			run_q.push_back(t);
		endfunction

		// a character seen with no token pending
		function void plain_char(char_t c, field_t p);
			if (c == btl_pkg::CH_LF) begin
				if (line_no != btl_pkg::LINE_MAX)
					line_no = line_no + 1'b1;
				line_base = bump(p);
			end else if (c == btl_pkg::CH_QUOTE) begin
				scan = SCAN_STRING;
				tok_start = bump(p);
			end else begin
				case (c)
					CH_LPAREN: emit(btl_pkg::KIND_LPAREN, p, field_t'(1));
					CH_RPAREN: emit(btl_pkg::KIND_RPAREN, p, field_t'(1));
					CH_PLUS:   emit(btl_pkg::KIND_PLUS, p, field_t'(1));
					CH_MINUS:  emit(btl_pkg::KIND_MINUS, p, field_t'(1));
					CH_STAR:   emit(btl_pkg::KIND_STAR, p, field_t'(1));
					CH_SLASH:  emit(btl_pkg::KIND_SLASH, p, field_t'(1));
					CH_COMMA:  emit(btl_pkg::KIND_COMMA, p, field_t'(1));
					CH_SEMI:   emit(btl_pkg::KIND_SEMI, p, field_t'(1));
					default: begin
						if (alpha(c)) begin
							scan = SCAN_IDENT;
							tok_start = p;
						end else if (numeral(c)) begin
							scan = SCAN_NUMBER;
							tok_start = p;
						end
					end
				endcase
			end
		endfunction

		function void take_char(char_t c, logic fin);
			field_t p;
			field_t nxt;
			btl_pkg::tok_t t;
			p = cursor;
			nxt = bump(p);
			run_q.delete();
			case (scan)
				SCAN_STRING: begin
					if (c == btl_pkg::CH_QUOTE) begin
						scan = SCAN_IDLE;
						emit(btl_pkg::KIND_STRING, tok_start,
							(p >= tok_start) ? field_t'(p - tok_start) : '0);
					end
				end
				SCAN_IDENT: begin
					if (!alpha(c) && !numeral(c)) begin
						scan = SCAN_IDLE;
						if (c == btl_pkg::CH_DOLLAR) begin
							emit(btl_pkg::KIND_IDENT, tok_start, field_t'(nxt - tok_start));
						end else begin
							emit(btl_pkg::KIND_IDENT, tok_start, field_t'(p - tok_start));
							plain_char(c, p);
						end
					end
				end
				SCAN_NUMBER: begin
					if (!numeral(c)) begin
						scan = SCAN_IDLE;
						emit(btl_pkg::KIND_NUMBER, tok_start, field_t'(p - tok_start));
						plain_char(c, p);
					end
				end
				default: plain_char(c, p);
			endcase
			cursor = nxt;
			if (fin) begin
				case (scan)
					SCAN_IDENT:  emit(btl_pkg::KIND_IDENT, tok_start,
						field_t'(cursor - tok_start));
					SCAN_NUMBER: emit(btl_pkg::KIND_NUMBER, tok_start,
						field_t'(cursor - tok_start));
					SCAN_STRING: emit(btl_pkg::KIND_UNTERM, tok_start,
						(cursor >= tok_start) ? field_t'(cursor - tok_start) : '0);
					default: ;
				endcase
				emit(btl_pkg::KIND_END, cursor, '0);
				restart();
			end
			if (run_q.size() > 0) begin
				t = run_q.pop_back();
				t.last_of_run = 1'b1;
				run_q.push_back(t);
			end
			foreach (run_q[i])
				due_tokens.push_back(run_q[i]);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("mismatch at %0t ns: %s", $time, msg);
		endtask

		task cmp_field(string name, field_t got, field_t want);
			if (got !== want)
				report($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task match_token(btl_pkg::tok_t got);
			btl_pkg::tok_t want;
			if (due_tokens.size() == 0) begin
				report($sformatf("token kind %0d offset %0d with none pending",
					got.token_kind, got.start_offset));
				return;
			end
			want = due_tokens.pop_front();
			cmp_field("token_kind", field_t'(got.token_kind), field_t'(want.token_kind));
			cmp_field("start_offset", got.start_offset, want.start_offset);
			cmp_field("token_length", got.token_length, want.token_length);
			cmp_field("line_number", got.line_number, want.line_number);
			cmp_field("column_number", got.column_number, want.column_number);
			cmp_field("last_of_run", field_t'(got.last_of_run), field_t'(want.last_of_run));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int src_idle_pct = 9;
	int snk_idle_pct = 57;
	char_t text_bytes[$];
	token_board board = new();

	btl_char_if chars();
	btl_tok_if tokens();

	basic_token_lexer #(
		.OFFSET_BITS(btl_pkg::OFFSET_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.tokens(tokens)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("[basic_token_lexer] ERROR");
		$finish;
	end

	// token side: random back-pressure
	initial begin
		tokens.ready = 1'b0;
		forever begin
			@(negedge clk);
			tokens.ready = ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tokens.valid === 1'b1 && tokens.ready === 1'b1)
			board.match_token({tokens.token_kind, tokens.start_offset, tokens.token_length,
				tokens.line_number, tokens.column_number, tokens.last_of_run});
	end

	task automatic push_char(char_t c, logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			chars.valid = 1'b0;
			@(negedge clk);
		end
		chars.valid = 1'b1;
		chars.char_code = c;
		chars.is_final = fin;
		do @(posedge clk); while (chars.ready !== 1'b1);
		board.take_char(c, fin);
		@(negedge clk);
	endtask

	task automatic push_text(string s, logic fin_last);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], fin_last && (i == s.len() - 1));
	endtask

	function automatic char_t rand_letter();
		return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
			: 8'(8'h41 + $urandom_range(25));
	endfunction

	function automatic char_t rand_digit();
		return 8'(8'h30 + $urandom_range(9));
	endfunction

	function automatic char_t rand_op();
		case ($urandom_range(7))
			0: return CH_LPAREN;
			1: return CH_RPAREN;
			2: return CH_PLUS;
			3: return CH_MINUS;
			4: return CH_STAR;
			5: return CH_SLASH;
			6: return CH_COMMA;
			default: return CH_SEMI;
		endcase
	endfunction

	// mostly well-formed tokens, some noise and broken strings
	function automatic void fill_text();
		char_t b;
		text_bytes.delete();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(11))
				0, 1: begin
					text_bytes.push_back(rand_letter());
					repeat ($urandom_range(0, 4))
						text_bytes.push_back($urandom_range(2) == 0 ? rand_digit() : rand_letter());
					if ($urandom_range(3) == 0)
						text_bytes.push_back(btl_pkg::CH_DOLLAR);
				end
				2: begin
					repeat ($urandom_range(1, 4))
						text_bytes.push_back(rand_digit());
				end
				3: begin
					text_bytes.push_back(btl_pkg::CH_QUOTE);
					repeat ($urandom_range(0, 4)) begin
						b = ($urandom_range(4) == 0) ? btl_pkg::CH_LF : 8'($urandom_range(32, 126));
						if (b == btl_pkg::CH_QUOTE)
							b = btl_pkg::CH_LF;
						text_bytes.push_back(b);
					end
					if ($urandom_range(7) != 0)
						text_bytes.push_back(btl_pkg::CH_QUOTE);
				end
				4, 5, 6: text_bytes.push_back(rand_op());
				7: begin
					case ($urandom_range(3))
						0: text_bytes.push_back(CH_SPACE);
						1: text_bytes.push_back(CH_TAB);
						2: text_bytes.push_back(CH_CR);
						default: text_bytes.push_back(btl_pkg::CH_LF);
					endcase
				end
				8: text_bytes.push_back(CH_SPACE);
				9: text_bytes.push_back(btl_pkg::CH_LF);
				10: text_bytes.push_back(8'($urandom_range(255)));
				default: text_bytes.push_back(btl_pkg::CH_DOLLAR);
			endcase
		end
	endfunction

	task automatic random_texts(int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			fill_text();
			foreach (text_bytes[i])
				push_char(text_bytes[i], i == text_bytes.size() - 1);
			sent += text_bytes.size();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_code = '0;
		chars.is_final = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles little, receiver stalls often
		src_idle_pct = 9;
		snk_idle_pct = 57;
		push_text("Zz9$(\t0\"\",\"\n\"\n", 1'b0);
		push_char(8'hff, 1'b0);
		push_text("x;-*/+)\r", 1'b0);
		push_text("7", 1'b1);
		push_text("\"q", 1'b1);
		random_texts(87);

		src_idle_pct = 57;
		snk_idle_pct = 9;
		random_texts(87);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_texts(86);

		chars.valid = 1'b0;
		while (board.due_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("[basic_token_lexer] OK");
		else
			$display("[basic_token_lexer] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/btl_pkg.sv
rtl/btl_char_if.sv
rtl/btl_tok_if.sv
rtl/btl_scan.sv
rtl/btl_rbuf.sv
rtl/basic_token_lexer.sv
rtl/btl_check.sv
tb/basic_token_lexer_tb.sv
